FILE: hw/rtl/pfw_pkg.sv
`timescale 1ns / 1ps

package pfw_pkg;

  // Ring and waiter table sizes
  localparam int DEPTH   = 1024;
  localparam int WAITERS = 4;
  localparam int MAX_RUN = 64;

  // Field widths
  localparam int OP_W    = 3;
  localparam int DATA_W  = 8;
  localparam int ID_W    = 8;
  localparam int SIZE_W  = 7;
  localparam int KIND_W  = 3;
  localparam int FILL_W  = 11;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - ID_W - FILL_W;

  // Derived widths
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int POS_W  = IDX_W + 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int SLOT_W = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int CMP_A  = (CNT_W > RUN_W) ? CNT_W : RUN_W;
  localparam int CMP_W  = (CMP_A > SIZE_W) ? CMP_A : SIZE_W;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_CLOSE_R = 3'd2,
    OP_CLOSE_W = 3'd3,
    OP_OPEN    = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 3'd0,
    KIND_WDONE   = 3'd1,
    KIND_WAKE    = 3'd2,
    KIND_WAITING = 3'd3,
    KIND_NOSLOT  = 3'd4,
    KIND_EOF     = 3'd5,
    KIND_BROKEN  = 3'd6,
    KIND_ACK     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAKE,
    ST_ACK
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] data;
    logic [ID_W-1:0]   who;
    logic [FILL_W-1:0] fill;
    logic              last;
  } res_t;

  function automatic res_t mk_res(kind_t kind, logic [DATA_W-1:0] data,
                                  logic [ID_W-1:0] who, logic [FILL_W-1:0] fill,
                                  logic last);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.who  = who;
    r.fill = fill;
    r.last = last;
    return r;
  endfunction

  // Lowest set bit of a waiter mask
  function automatic logic [SLOT_W-1:0] first_set(logic [WAITERS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = WAITERS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/pfw_ram.sv
`timescale 1ns / 1ps

module pfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/pipe_fifo_with_reader_wakeup.sv
`timescale 1ns / 1ps
// Byte pipe with a table of blocked readers. Each input word carries one
// operation in in_tuser: write byte, read request, close read, close write or
// open. Bytes live in a 1024-entry ring held in a single synchronous RAM;
// waiters (four slots) sit in flops. Every result word leaves through one
// output register, and the block takes a new word only while that register is
// empty or draining in the same cycle, so a result held by a low out_tready
// also holds off in_tready. The result stream of one word always ends with
// out_tlast set. A read run first waits on the RAM read of its first byte,
// after which the store's read port delivers one byte per cycle while the
// output is not stalled; the last byte of a write call that wakes W readers
// emits its done result and then one wake per reader; a close write that wakes
// W readers emits the wakes and the trailing ack following the accepting cycle.
// The single output register emits one result per cycle unless out_tready
// stalls it. No word is accepted while a run or a scan is in progress. After
// reset the block is ready at once; the ring needs no clearing since a byte is
// read only after it was written.

module pipe_fifo_with_reader_wakeup (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] data, [15:8] reader, [22:16] read_size, [23] zero
  input  logic [pfw_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,  // last byte of a write call
  // [2:0] operation
  input  logic [pfw_pkg::OP_W-1:0]           in_tuser,

  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] data_res, [15:8] woken_reader, [26:16] fill, [31:27] zero
  output logic [pfw_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast, // end_of_run
  // [2:0] kind
  output logic [pfw_pkg::KIND_W-1:0]         out_tuser
);

  // ---------------------------------------------------------------------------
  // Input word decode
  // ---------------------------------------------------------------------------
  pfw_pkg::op_t                  op;
  logic [pfw_pkg::DATA_W-1:0]    in_data;
  logic [pfw_pkg::ID_W-1:0]      in_reader;
  logic [pfw_pkg::SIZE_W-1:0]    in_size;

  assign op        = pfw_pkg::op_t'(in_tuser);
  assign in_data   = in_tdata[pfw_pkg::DATA_W-1:0];
  assign in_reader = in_tdata[pfw_pkg::DATA_W +: pfw_pkg::ID_W];
  assign in_size   = in_tdata[pfw_pkg::DATA_W + pfw_pkg::ID_W +: pfw_pkg::SIZE_W];

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  pfw_pkg::state_t               state_r, state_nxt;

  logic                          out_valid_r, out_valid_nxt;
  pfw_pkg::res_t                 out_res_r, out_res_nxt;

  logic [pfw_pkg::IDX_W-1:0]     head_r, head_nxt;
  logic [pfw_pkg::CNT_W-1:0]     held_r, held_nxt;
  logic                          read_open_r, read_open_nxt;
  logic                          write_open_r, write_open_nxt;
  logic [pfw_pkg::CNT_W-1:0]     call_r, call_nxt;
  logic [pfw_pkg::WAITERS-1:0]   wv_r, wv_nxt;
  logic                          wake_all_r, wake_all_nxt;

  logic [pfw_pkg::ID_W-1:0]      wid_r   [pfw_pkg::WAITERS];
  logic [pfw_pkg::ID_W-1:0]      wid_nxt [pfw_pkg::WAITERS];
  logic [pfw_pkg::SIZE_W-1:0]    wwant_r   [pfw_pkg::WAITERS];
  logic [pfw_pkg::SIZE_W-1:0]    wwant_nxt [pfw_pkg::WAITERS];
  logic [pfw_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [pfw_pkg::RUN_W-1:0]     cnt_r, cnt_nxt;
  logic [pfw_pkg::IDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;

  // Store RAM port
  logic                          ram_we;
  logic [pfw_pkg::IDX_W-1:0]     ram_waddr;
  logic                          ram_re;
  logic [pfw_pkg::IDX_W-1:0]     ram_raddr;
  logic [pfw_pkg::DATA_W-1:0]    ram_rdata;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic can_load;
  logic accept;

  // Output register is free this cycle when empty or being drained.
  assign can_load  = !out_valid_r || out_tready;
  assign in_tready = (state_r == pfw_pkg::ST_IDLE) && can_load;
  assign accept    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Waiter table lookups
  // ---------------------------------------------------------------------------
  logic                          any_valid;
  logic                          has_free;
  logic [pfw_pkg::SLOT_W-1:0]    wake_slot;
  logic [pfw_pkg::SLOT_W-1:0]    free_slot;
  logic [pfw_pkg::WAITERS-1:0]   wv_after;
  logic                          more_valid;
  logic [pfw_pkg::SIZE_W-1:0]    wake_want;
  logic                          wake_stop;

  assign any_valid  = |wv_r;
  assign has_free   = ~&wv_r;
  assign wake_slot  = pfw_pkg::first_set(wv_r);
  assign free_slot  = pfw_pkg::first_set(~wv_r);
  assign wv_after   = wv_r & ~(pfw_pkg::WAITERS'(1) << wake_slot);
  assign more_valid = |wv_after;
  assign wake_want  = wwant_r[wake_slot];
  // Stop the scan once this reader covers what the call left unaccounted.
  assign wake_stop  = pfw_pkg::CMP_W'(wake_want) >= pfw_pkg::CMP_W'(rem_r);

  // ---------------------------------------------------------------------------
  // Write and read arithmetic
  // ---------------------------------------------------------------------------
  logic                          can_store;
  logic [pfw_pkg::CNT_W-1:0]     call_new;
  logic [pfw_pkg::POS_W-1:0]     tail_sum;
  logic [pfw_pkg::IDX_W-1:0]     tail_idx;
  logic [pfw_pkg::RUN_W-1:0]     want_clamp;
  logic [pfw_pkg::RUN_W-1:0]     run_len;
  logic [pfw_pkg::POS_W-1:0]     head_sum;
  logic [pfw_pkg::IDX_W-1:0]     head_adv;
  logic [pfw_pkg::IDX_W-1:0]     rd_ptr_inc;
  logic [pfw_pkg::FILL_W-1:0]    held_fill;

  assign can_store = write_open_r && (held_r < pfw_pkg::CNT_W'(pfw_pkg::DEPTH));
  assign call_new  = can_store ? call_r + pfw_pkg::CNT_W'(1) : call_r;

  // Tail = head + held, wrapped once.
  assign tail_sum = pfw_pkg::POS_W'(head_r) + pfw_pkg::POS_W'(held_r);
  assign tail_idx = (tail_sum >= pfw_pkg::POS_W'(pfw_pkg::DEPTH))
                  ? pfw_pkg::IDX_W'(tail_sum - pfw_pkg::POS_W'(pfw_pkg::DEPTH))
                  : pfw_pkg::IDX_W'(tail_sum);

  // Run length: request clamped to the run limit, then to the bytes held.
  assign want_clamp = (pfw_pkg::CMP_W'(in_size) > pfw_pkg::CMP_W'(pfw_pkg::MAX_RUN))
                    ? pfw_pkg::RUN_W'(pfw_pkg::MAX_RUN)
                    : pfw_pkg::RUN_W'(in_size);
  assign run_len    = (pfw_pkg::CMP_W'(want_clamp) > pfw_pkg::CMP_W'(held_r))
                    ? pfw_pkg::RUN_W'(held_r)
                    : want_clamp;

  assign head_sum = pfw_pkg::POS_W'(head_r) + pfw_pkg::POS_W'(run_len);
  assign head_adv = (head_sum >= pfw_pkg::POS_W'(pfw_pkg::DEPTH))
                  ? pfw_pkg::IDX_W'(head_sum - pfw_pkg::POS_W'(pfw_pkg::DEPTH))
                  : pfw_pkg::IDX_W'(head_sum);

  assign rd_ptr_inc = (rd_ptr_r == pfw_pkg::IDX_W'(pfw_pkg::DEPTH - 1))
                    ? '0 : rd_ptr_r + pfw_pkg::IDX_W'(1);

  assign held_fill = pfw_pkg::FILL_W'(held_r);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfw_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            pfw_pkg::OP_WRITE: begin
              if (read_open_r && in_tlast && any_valid) begin
                state_nxt = pfw_pkg::ST_WAKE;
              end
            end
            pfw_pkg::OP_READ: begin
              if (read_open_r && (held_r != '0) && (run_len != '0)) begin
                state_nxt = pfw_pkg::ST_RUN;
              end
            end
            pfw_pkg::OP_CLOSE_W: begin
              if (read_open_r && any_valid) begin
                state_nxt = pfw_pkg::ST_WAKE;
              end
            end
            default: ;
          endcase
        end
      end
      pfw_pkg::ST_RUN: begin
        if (can_load && (cnt_r == pfw_pkg::RUN_W'(1))) begin
          state_nxt = pfw_pkg::ST_IDLE;
        end
      end
      pfw_pkg::ST_WAKE: begin
        if (can_load) begin
          if (wake_all_r) begin
            if (!more_valid) begin
              state_nxt = pfw_pkg::ST_ACK;
            end
          end else if (wake_stop || !more_valid) begin
            state_nxt = pfw_pkg::ST_IDLE;
          end
        end
      end
      pfw_pkg::ST_ACK: begin
        if (can_load) begin
          state_nxt = pfw_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath, result register and store access
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_res_nxt    = out_res_r;
    head_nxt       = head_r;
    held_nxt       = held_r;
    read_open_nxt  = read_open_r;
    write_open_nxt = write_open_r;
    call_nxt       = call_r;
    wv_nxt         = wv_r;
    wake_all_nxt   = wake_all_r;
    wid_nxt        = wid_r;
    wwant_nxt      = wwant_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    rd_ptr_nxt     = rd_ptr_r;
    ram_we         = 1'b0;
    ram_waddr      = tail_idx;
    ram_re         = 1'b0;
    ram_raddr      = rd_ptr_r;

    unique case (state_r)
      pfw_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            pfw_pkg::OP_WRITE: begin
              if (!read_open_r) begin
                // Reader gone: drop the byte, report broken pipe on the last one.
                if (in_tlast) begin
                  out_valid_nxt = 1'b1;
                  out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_BROKEN, '0, '0,
                                                  held_fill, 1'b1);
                  call_nxt      = '0;
                end
              end else begin
                if (can_store) begin
                  ram_we   = 1'b1;
                  held_nxt = held_r + pfw_pkg::CNT_W'(1);
                end
                if (in_tlast) begin
                  out_valid_nxt = 1'b1;
                  out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_WDONE, '0, '0,
                                                  pfw_pkg::FILL_W'(call_new), !any_valid);
                  rem_nxt       = call_new;
                  call_nxt      = '0;
                  wake_all_nxt  = 1'b0;
                end else begin
                  call_nxt = call_new;
                end
              end
            end
            pfw_pkg::OP_READ: begin
              if (!read_open_r) begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_EOF, '0, '0, held_fill, 1'b1);
              end else if (held_r == '0) begin
                out_valid_nxt = 1'b1;
                if (!write_open_r) begin
                  out_res_nxt = pfw_pkg::mk_res(pfw_pkg::KIND_EOF, '0, '0, held_fill, 1'b1);
                end else if (has_free) begin
                  // Park the reader in the lowest free slot.
                  wv_nxt[free_slot]    = 1'b1;
                  wid_nxt[free_slot]   = in_reader;
                  wwant_nxt[free_slot] = in_size;
                  out_res_nxt = pfw_pkg::mk_res(pfw_pkg::KIND_WAITING, '0, '0,
                                                held_fill, 1'b1);
                end else begin
                  out_res_nxt = pfw_pkg::mk_res(pfw_pkg::KIND_NOSLOT, '0, '0,
                                                held_fill, 1'b1);
                end
              end else if (run_len == '0) begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_ACK, '0, '0, held_fill, 1'b1);
              end else begin
                // Commit the run now; bytes follow from the store one per cycle while the output drains.
                held_nxt   = held_r - pfw_pkg::CNT_W'(run_len);
                head_nxt   = head_adv;
                rd_ptr_nxt = head_r;
                cnt_nxt    = run_len;
                ram_re     = 1'b1;
                ram_raddr  = head_r;
              end
            end
            pfw_pkg::OP_CLOSE_R: begin
              read_open_nxt = 1'b0;
              held_nxt      = '0;
              head_nxt      = '0;
              call_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_ACK, '0, '0, '0, 1'b1);
            end
            pfw_pkg::OP_CLOSE_W: begin
              write_open_nxt = 1'b0;
              if (read_open_r && any_valid) begin
                wake_all_nxt = 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_ACK, '0, '0, held_fill, 1'b1);
              end
            end
            pfw_pkg::OP_OPEN: begin
              head_nxt       = '0;
              held_nxt       = '0;
              read_open_nxt  = 1'b1;
              write_open_nxt = 1'b1;
              call_nxt       = '0;
              wv_nxt         = '0;
              out_valid_nxt  = 1'b1;
              out_res_nxt    = pfw_pkg::mk_res(pfw_pkg::KIND_ACK, '0, '0, '0, 1'b1);
            end
            default: ;
          endcase
        end
      end
      pfw_pkg::ST_RUN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_DATA, ram_rdata, '0, held_fill,
                                          cnt_r == pfw_pkg::RUN_W'(1));
          cnt_nxt       = cnt_r - pfw_pkg::RUN_W'(1);
          // Fetch the next byte while this one goes out.
          if (cnt_r != pfw_pkg::RUN_W'(1)) begin
            rd_ptr_nxt = rd_ptr_inc;
            ram_re     = 1'b1;
            ram_raddr  = rd_ptr_inc;
          end
        end
      end
      pfw_pkg::ST_WAKE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_WAKE, '0, wid_r[wake_slot],
                                          held_fill,
                                          !wake_all_r && (wake_stop || !more_valid));
          wv_nxt        = wv_after;
          if (!wake_all_r && !wake_stop) begin
            rem_nxt = rem_r - pfw_pkg::CNT_W'(wake_want);
          end
        end
      end
      pfw_pkg::ST_ACK: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = pfw_pkg::mk_res(pfw_pkg::KIND_ACK, '0, '0, held_fill, 1'b1);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfw_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      head_r       <= '0;
      held_r       <= '0;
      read_open_r  <= 1'b1;
      write_open_r <= 1'b1;
      call_r       <= '0;
      wv_r         <= '0;
      wake_all_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      head_r       <= head_nxt;
      held_r       <= held_nxt;
      read_open_r  <= read_open_nxt;
      write_open_r <= write_open_nxt;
      call_r       <= call_nxt;
      wv_r         <= wv_nxt;
      wake_all_r   <= wake_all_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    wid_r     <= wid_nxt;
    wwant_r   <= wwant_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
  end

  // ---------------------------------------------------------------------------
  // Byte store
  // ---------------------------------------------------------------------------
  pfw_ram #(
    .WIDTH (pfw_pkg::DATA_W),
    .DEPTH (pfw_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result port
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {{pfw_pkg::OUT_PAD_W{1'b0}}, out_res_r.fill, out_res_r.who,
                       out_res_r.data};

endmodule

FILE: hw/rtl/pfw_checker.sv
`timescale 1ns / 1ps

module pfw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pfw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic [pfw_pkg::KIND_W-1:0]      out_tuser
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result word changed");

  // Drop any pending result on reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != pfw_pkg::KIND_DATA) |-> out_tdata[7:0] == 8'h00)
    else $error("byte field set on a non-data result");

  // Single-result answers always close their run.
  a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == pfw_pkg::KIND_ACK || out_tuser == pfw_pkg::KIND_EOF ||
                   out_tuser == pfw_pkg::KIND_BROKEN || out_tuser == pfw_pkg::KIND_WAITING ||
                   out_tuser == pfw_pkg::KIND_NOSLOT) |-> out_tlast)
    else $error("terminal result without tlast");

endmodule

bind pipe_fifo_with_reader_wakeup pfw_checker u_pfw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
